FILE: design/slfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfc_pkg - shared types and constants of the sensor link frame codec
// Item and job layouts, frame bytes, measurement frame positions, queue sizing.
// ----------------------------------------------------------------------------
package slfc_pkg;

  localparam int MAX_PAYLOAD    = 5;
  localparam int PAY_FIELDS     = 5;
  localparam int PAY_CAP        = (MAX_PAYLOAD < PAY_FIELDS) ? MAX_PAYLOAD : PAY_FIELDS;
  localparam int MEAS_FRAME_LEN = 12;

  // frame index runs over AA 99 cmd len payload csum AA AA
  localparam int IDX_W  = $clog2(PAY_CAP + 7);
  localparam int POS_W  = 4;
  localparam int LEN_W  = 3;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // stream word layout
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 3;
  localparam int IN_LEN_LSB  = 8;
  localparam int IN_PAY_LSB  = 11;
  localparam int IN_RX_LSB   = IN_PAY_LSB + 8 * PAY_FIELDS;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  localparam logic [7:0] BYTE_SYNC     = 8'hAA;
  localparam logic [7:0] BYTE_CMD_MARK = 8'h99;
  localparam logic [7:0] BYTE_ACK_TAIL = 8'h79;
  localparam logic [7:0] BYTE_ONES     = 8'hFF;

  localparam pos_t MEAS_LAST_POS = pos_t'(MEAS_FRAME_LEN - 1);
  localparam pos_t TEMP_HI_POS   = pos_t'(7);
  localparam pos_t TEMP_LO_POS   = pos_t'(8);
  localparam pos_t HUM_POS       = pos_t'(10);

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_MEAS = 2'd1,
    ACT_ACK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_MEAS = 2'd1,
    KIND_ACK  = 2'd2
  } kind_t;

  typedef struct packed {
    action_t                    action;
    logic [7:0]                 cmd;
    len_t                       payload_len;
    logic [PAY_FIELDS-1:0][7:0] pay;
    logic [7:0]                 rx_byte;
    logic                       rx_first;
    logic                       rx_end;
  } in_item_t;

  typedef struct packed {
    kind_t                      kind;
    logic [7:0]                 cmd;
    len_t                       len;
    logic [PAY_FIELDS-1:0][7:0] pay;
    logic [7:0]                 csum;
    logic [15:0]                temp;
    logic [7:0]                 hum;
    logic                       cks_ok;
    logic                       ack_ok;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } job_req_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

endpackage

FILE: design/slfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfc_front - item classifier
// Track measurement and acknowledge frames and turn each result-bearing item into a job.
// ----------------------------------------------------------------------------
module slfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  slfc_pkg::in_item_t  item,
  output slfc_pkg::job_req_t  req
);

  slfc_pkg::pos_t pos_r, pos_nxt;
  logic [7:0]     xor_r, xor_nxt;
  logic [7:0]     temp_hi_r, temp_hi_nxt;
  logic [7:0]     temp_lo_r, temp_lo_nxt;
  logic [7:0]     hum_r, hum_nxt;
  logic           head_good_r, head_good_nxt;

  slfc_pkg::len_t len_sat;
  logic [7:0]     csum;
  logic           head_now;

  // saturate length and fold the checksum of a send item
  always_comb begin
    logic [7:0] x;
    len_sat = (item.payload_len > slfc_pkg::len_t'(slfc_pkg::PAY_CAP)) ?
              slfc_pkg::len_t'(slfc_pkg::PAY_CAP) : item.payload_len;
    x = item.cmd ^ {5'b0, len_sat};
    for (int i = 0; i < slfc_pkg::PAY_FIELDS; i++) begin
      if (slfc_pkg::len_t'(i) < len_sat) begin
        x = x ^ item.pay[i];
      end
    end
    csum = slfc_pkg::BYTE_ONES ^ x;
  end

  assign head_now = item.rx_first ? (item.rx_byte == slfc_pkg::BYTE_SYNC) : head_good_r;

  always_comb begin
    pos_nxt       = pos_r;
    xor_nxt       = xor_r;
    temp_hi_nxt   = temp_hi_r;
    temp_lo_nxt   = temp_lo_r;
    hum_nxt       = hum_r;
    head_good_nxt = head_good_r;
    req           = '0;
    req.job.cmd   = item.cmd;
    req.job.len   = len_sat;
    req.job.pay   = item.pay;
    req.job.csum  = csum;
    if (accept) begin
      unique case (item.action)
        slfc_pkg::ACT_SEND: begin
          req.push     = 1'b1;
          req.job.kind = slfc_pkg::KIND_TX;
        end
        slfc_pkg::ACT_MEAS: begin
          if (pos_r >= slfc_pkg::MEAS_LAST_POS) begin
            req.push       = 1'b1;
            req.job.kind   = slfc_pkg::KIND_MEAS;
            req.job.temp   = {temp_hi_r, temp_lo_r};
            req.job.hum    = hum_r;
            req.job.cks_ok = ((slfc_pkg::BYTE_ONES ^ xor_r) == item.rx_byte);
            pos_nxt        = '0;
            xor_nxt        = '0;
          end else begin
            if (pos_r == slfc_pkg::TEMP_HI_POS) temp_hi_nxt = item.rx_byte;
            if (pos_r == slfc_pkg::TEMP_LO_POS) temp_lo_nxt = item.rx_byte;
            if (pos_r == slfc_pkg::HUM_POS)     hum_nxt     = item.rx_byte;
            xor_nxt = xor_r ^ item.rx_byte;
            pos_nxt = pos_r + slfc_pkg::pos_t'(1);
          end
        end
        slfc_pkg::ACT_ACK: begin
          head_good_nxt = head_now;
          if (item.rx_end) begin
            req.push       = 1'b1;
            req.job.kind   = slfc_pkg::KIND_ACK;
            req.job.ack_ok = head_now && (item.rx_byte == slfc_pkg::BYTE_ACK_TAIL);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      xor_r       <= '0;
      head_good_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      head_good_r <= head_good_nxt;
    end
  end

  // capture bytes are always written before a verdict reads them
  always_ff @(posedge clk) begin
    temp_hi_r <= temp_hi_nxt;
    temp_lo_r <= temp_lo_nxt;
    hum_r     <= hum_nxt;
  end

endmodule

FILE: design/slfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfc_queue - job queue
// Short FIFO of jobs between the classifier and the serializer.
// ----------------------------------------------------------------------------
module slfc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  slfc_pkg::job_req_t  req,
  input  logic                pop,
  output slfc_pkg::job_head_t head,
  output logic                full
);

  slfc_pkg::job_t  mem_r [slfc_pkg::Q_DEPTH];
  slfc_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  slfc_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  slfc_pkg::qcnt_t cnt_r, cnt_nxt;

  function automatic slfc_pkg::qptr_t ptr_inc(input slfc_pkg::qptr_t p);
    ptr_inc = (p == slfc_pkg::qptr_t'(slfc_pkg::Q_DEPTH - 1)) ? '0 : p + slfc_pkg::qptr_t'(1);
  endfunction

  assign full       = (cnt_r == slfc_pkg::qcnt_t'(slfc_pkg::Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = req.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    unique case ({req.push, pop})
      2'b10:   cnt_nxt = cnt_r + slfc_pkg::qcnt_t'(1);
      2'b01:   cnt_nxt = cnt_r - slfc_pkg::qcnt_t'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem_r[wr_ptr_r] <= req.job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.push && full))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head.valid))
    else $error("job popped from an empty queue");

endmodule

FILE: design/slfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfc_back - result serializer
// Walk a send job byte by byte, pass verdicts, hold the result word register.
// ----------------------------------------------------------------------------
module slfc_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  slfc_pkg::job_head_t                    head,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [slfc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [slfc_pkg::OUT_TUSER_W-1:0]       out_tuser,
  output logic                                   out_tlast
);

  slfc_pkg::idx_t  idx_r, idx_nxt;
  logic            valid_r, valid_nxt;
  slfc_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]      tx_r, tx_nxt;
  logic            last_r, last_nxt;
  logic [15:0]     temp_r, temp_nxt;
  logic [7:0]      hum_r, hum_nxt;
  logic            cks_r, cks_nxt;
  logic            ack_r, ack_nxt;

  logic            load;
  slfc_pkg::idx_t  pidx;
  slfc_pkg::idx_t  len_ext;
  slfc_pkg::idx_t  last_idx;
  logic [7:0]      frame_byte;
  logic [7:0]      pay_byte;

  assign load     = !valid_r || out_tready;
  assign len_ext  = slfc_pkg::idx_t'(head.job.len);
  assign last_idx = len_ext + slfc_pkg::idx_t'(6);
  assign pidx     = idx_r - slfc_pkg::idx_t'(4);

  always_comb begin
    pay_byte = '0;
    for (int i = 0; i < slfc_pkg::PAY_FIELDS; i++) begin
      if (pidx == slfc_pkg::idx_t'(i)) pay_byte = head.job.pay[i];
    end
  end

  // byte at the current frame position
  always_comb begin
    priority if (idx_r == slfc_pkg::idx_t'(0)) frame_byte = slfc_pkg::BYTE_SYNC;
    else if (idx_r == slfc_pkg::idx_t'(1))     frame_byte = slfc_pkg::BYTE_CMD_MARK;
    else if (idx_r == slfc_pkg::idx_t'(2))     frame_byte = head.job.cmd;
    else if (idx_r == slfc_pkg::idx_t'(3))     frame_byte = {5'b0, head.job.len};
    else if (pidx < len_ext)                   frame_byte = pay_byte;
    else if (pidx == len_ext)                  frame_byte = head.job.csum;
    else                                       frame_byte = slfc_pkg::BYTE_SYNC;
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    tx_nxt    = tx_r;
    last_nxt  = last_r;
    temp_nxt  = temp_r;
    hum_nxt   = hum_r;
    cks_nxt   = cks_r;
    ack_nxt   = ack_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = head.valid;
      if (head.valid) begin
        kind_nxt = head.job.kind;
        tx_nxt   = '0;
        last_nxt = 1'b0;
        temp_nxt = '0;
        hum_nxt  = '0;
        cks_nxt  = 1'b0;
        ack_nxt  = 1'b0;
        unique case (head.job.kind)
          slfc_pkg::KIND_TX: begin
            tx_nxt = frame_byte;
            if (idx_r == last_idx) begin
              last_nxt = 1'b1;
              pop      = 1'b1;
              idx_nxt  = '0;
            end else begin
              idx_nxt = idx_r + slfc_pkg::idx_t'(1);
            end
          end
          slfc_pkg::KIND_MEAS: begin
            temp_nxt = head.job.temp;
            hum_nxt  = head.job.hum;
            cks_nxt  = head.job.cks_ok;
            pop      = 1'b1;
          end
          slfc_pkg::KIND_ACK: begin
            ack_nxt = head.job.ack_ok;
            pop     = 1'b1;
          end
          default: begin
            pop = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    tx_r   <= tx_nxt;
    last_r <= last_nxt;
    temp_r <= temp_nxt;
    hum_r  <= hum_nxt;
    cks_r  <= cks_nxt;
    ack_r  <= ack_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(slfc_pkg::OUT_TDATA_W - 34){1'b0}}, ack_r, cks_r, hum_r, temp_r, tx_r};

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= slfc_pkg::idx_t'(slfc_pkg::PAY_CAP + 6))
    else $error("frame index past the closing sync byte");

  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last_r) |-> (kind_r == slfc_pkg::KIND_TX))
    else $error("last flag on a verdict word");

  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != slfc_pkg::KIND_TX) |-> (tx_r == '0 && !last_r))
    else $error("verdict word carries a transmit byte");

  a_pop_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.job.kind == slfc_pkg::KIND_TX) |=> (valid_r && last_r && idx_r == '0))
    else $error("send job retired before its last byte");

endmodule

FILE: design/sensor_link_frame_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_link_frame_codec - sensor link framing engine
// Build command frames and check measurement and acknowledge responses.
// ----------------------------------------------------------------------------
// Path: the accepting edge writes the item's job into the job queue; the job
//   is then loaded into the output register once that register is free.
// Throughput: one input word per cycle while the two-entry job queue has room;
//   one result word per cycle while out_tready is high. A send item yields its
//   saturated length + 7 words, so the serializer sets the send item rate.
// Reset: synchronous, active low; clears frame counters, running checksum,
//   acknowledge head flag, job queue and output valid. No clearing pass.
module sensor_link_frame_codec (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // cmd[7:0], payload_len[10:8], pay0[18:11], pay1[26:19], pay2[34:27],
  // pay3[42:35], pay4[50:43], rx_byte[58:51], zero fill [63:59]
  input  logic [slfc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action[1:0], rx_first[2]
  input  logic [slfc_pkg::IN_TUSER_W-1:0]      in_tuser,
  // rx_end
  input  logic                                 in_tlast,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tx_byte[7:0], temperature_eighths[23:8], humidity_halves[31:24],
  // checksum_ok[32], ack_ok[33], zero fill [39:34]
  output logic [slfc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // kind[1:0]
  output logic [slfc_pkg::OUT_TUSER_W-1:0]     out_tuser,
  // last
  output logic                                 out_tlast
);

  slfc_pkg::in_item_t  item;
  slfc_pkg::job_req_t  req;
  slfc_pkg::job_head_t head;
  logic                accept;
  logic                pop;
  logic                q_full;

  // Unpack the input word into the item fields.
  always_comb begin
    item.action      = slfc_pkg::action_t'(in_tuser[1:0]);
    item.rx_first    = in_tuser[2];
    item.rx_end      = in_tlast;
    item.cmd         = in_tdata[7:0];
    item.payload_len = in_tdata[slfc_pkg::IN_LEN_LSB +: slfc_pkg::LEN_W];
    for (int i = 0; i < slfc_pkg::PAY_FIELDS; i++) begin
      item.pay[i] = in_tdata[slfc_pkg::IN_PAY_LSB + 8 * i +: 8];
    end
    item.rx_byte     = in_tdata[slfc_pkg::IN_RX_LSB +: 8];
  end

  // Take a word whenever the queue has a free slot; items that yield no
  // result pass through the classifier without touching the queue.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Classify: update frame trackers, form one job per result-bearing item.
  slfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .req    (req)
  );

  // Decouple classifier and serializer so each stalls on its own.
  slfc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // Serialize send jobs, forward verdicts, hold the output register.
  slfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: test/tb_sensor_link_frame_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_link_frame_codec - self-checking bench for the sensor link codec
// Offers send, measurement and acknowledge words with random gaps on both
// streams, predicts every result word in a small scoreboard class, and checks
// each word that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sensor_link_frame_codec;
  import slfc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RANDOM_ITEMS = 275;
  localparam int IDLE_PCT     = 24;
  // receiver hold-off long enough to fill the job queue and stall the input
  localparam int HOLD_CYCLES  = 160;
  // cycles with no accepted word before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  // the one action code the block ignores
  localparam action_t ACT_NONE = action_t'(2'd3);

  typedef struct {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       is_last;
    logic [15:0] temp;
    logic [7:0] hum;
    logic       cks_ok;
    logic       ack_ok;
  } link_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the receive state, queue of predicted words
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    pos_t       meas_pos;
    logic [7:0] meas_xor;
    logic [7:0] temp_hi;
    logic [7:0] temp_lo;
    logic [7:0] hum_byte;
    logic       ack_head;
    link_word_t expected_words[$];
    int         mismatches;

    function new();
      meas_pos   = '0;
      meas_xor   = '0;
      temp_hi    = '0;
      temp_lo    = '0;
      hum_byte   = '0;
      ack_head   = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function link_word_t blank_word(kind_t k);
      link_word_t w;
      w.kind    = k;
      w.tx_byte = '0;
      w.is_last = 1'b0;
      w.temp    = '0;
      w.hum     = '0;
      w.cks_ok  = 1'b0;
      w.ack_ok  = 1'b0;
      return w;
    endfunction

    function void queue_tx(logic [7:0] b, logic is_last);
      link_word_t w;
      w = blank_word(KIND_TX);
      w.tx_byte = b;
      w.is_last = is_last;
      expected_words.push_back(w);
    endfunction

    // Predict the words caused by one accepted input item.
    function void note_input(in_item_t it);
      link_word_t  w;
      int unsigned n;
      logic [7:0]  x;
      case (it.action)
        ACT_SEND: begin
          n = (it.payload_len > PAY_CAP) ? PAY_CAP : it.payload_len;
          queue_tx(BYTE_SYNC, 1'b0);
          queue_tx(BYTE_CMD_MARK, 1'b0);
          queue_tx(it.cmd, 1'b0);
          queue_tx(8'(n), 1'b0);
          x = it.cmd ^ 8'(n);
          for (int i = 0; i < n; i++) begin
            queue_tx(it.pay[i], 1'b0);
            x ^= it.pay[i];
          end
          queue_tx(BYTE_ONES - x, 1'b0);
          queue_tx(BYTE_SYNC, 1'b0);
          queue_tx(BYTE_SYNC, 1'b1);
        end
        ACT_MEAS: begin
          if (meas_pos >= MEAS_LAST_POS) begin
            w = blank_word(KIND_MEAS);
            w.temp   = {temp_hi, temp_lo};
            w.hum    = hum_byte;
            w.cks_ok = ((BYTE_ONES - meas_xor) == it.rx_byte);
            expected_words.push_back(w);
            meas_pos = '0;
            meas_xor = '0;
          end else begin
            if (meas_pos == TEMP_HI_POS) temp_hi = it.rx_byte;
            else if (meas_pos == TEMP_LO_POS) temp_lo = it.rx_byte;
            else if (meas_pos == HUM_POS) hum_byte = it.rx_byte;
            meas_xor ^= it.rx_byte;
            meas_pos = meas_pos + 1'b1;
          end
        end
        ACT_ACK: begin
          if (it.rx_first) ack_head = (it.rx_byte == BYTE_SYNC);
          if (it.rx_end) begin
            w = blank_word(KIND_ACK);
            w.ack_ok = ack_head && (it.rx_byte == BYTE_ACK_TAIL);
            expected_words.push_back(w);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatches++;
      $display("[%0t] %s: got %h want %h", $time, what, got, want);
    endtask

    // Compare one accepted result word with the oldest prediction.
    task check_result(logic [1:0] kind, logic [OUT_TDATA_W-1:0] data, logic is_last);
      link_word_t w;
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing pending", 16'(kind), 16'(data[7:0]));
      end else begin
        w = expected_words.pop_front();
        if (kind != w.kind)           report_mismatch("kind", 16'(kind), 16'(w.kind));
        if (data[7:0] != w.tx_byte)   report_mismatch("tx_byte", 16'(data[7:0]), 16'(w.tx_byte));
        if (is_last != w.is_last)     report_mismatch("last", 16'(is_last), 16'(w.is_last));
        if (data[23:8] != w.temp)     report_mismatch("temperature", data[23:8], w.temp);
        if (data[31:24] != w.hum)     report_mismatch("humidity", 16'(data[31:24]), 16'(w.hum));
        if (data[32] != w.cks_ok)     report_mismatch("checksum_ok", 16'(data[32]), 16'(w.cks_ok));
        if (data[33] != w.ack_ok)     report_mismatch("ack_ok", 16'(data[33]), 16'(w.ack_ok));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, stimulus signals, block under test
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  frame_scoreboard board = new();

  bit quiet        = 1'b0;   // both sides run without gaps while set
  bit hold_pending = 1'b0;   // ask the receiver for one long hold-off
  int items_sent   = 0;      // accepted words the block acts on

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  sensor_link_frame_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then note it on the scoreboard.
  task automatic drive_word(in_item_t it);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    // tdata: cmd, payload_len, pay0..pay4, rx_byte from the lowest bit up
    in_tdata  <= IN_TDATA_W'({it.rx_byte, it.pay, it.payload_len, it.cmd});
    in_tuser  <= {it.rx_first, it.action};
    in_tlast  <= it.rx_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(it);
    if (it.action != ACT_NONE) items_sent++;
  endtask

  // Fill every field at random so unused bits toggle too.
  function automatic in_item_t random_fields(action_t a);
    in_item_t it;
    it.action      = a;
    it.cmd         = 8'($urandom);
    it.payload_len = 3'($urandom);
    for (int i = 0; i < PAY_FIELDS; i++) it.pay[i] = 8'($urandom);
    it.rx_byte     = 8'($urandom);
    it.rx_first    = 1'($urandom);
    it.rx_end      = 1'($urandom);
    return it;
  endfunction

  task automatic push_send(logic [7:0] cmd, len_t len, logic [PAY_FIELDS-1:0][7:0] pay);
    in_item_t it;
    it = random_fields(ACT_SEND);
    it.cmd         = cmd;
    it.payload_len = len;
    it.pay         = pay;
    drive_word(it);
  endtask

  task automatic push_random_send();
    in_item_t it;
    it = random_fields(ACT_SEND);
    drive_word(it);
  endtask

  task automatic push_meas(logic [7:0] b);
    in_item_t it;
    it = random_fields(ACT_MEAS);
    it.rx_byte = b;
    drive_word(it);
  endtask

  task automatic push_ack(logic [7:0] b, logic first, logic tail);
    in_item_t it;
    it = random_fields(ACT_ACK);
    it.rx_byte  = b;
    it.rx_first = first;
    it.rx_end   = tail;
    drive_word(it);
  endtask

  // Stray words: ignored action, loose acknowledge byte, loose measurement byte.
  task automatic push_noise();
    logic [7:0] b;
    case ($urandom_range(3))
      0: drive_word(random_fields(ACT_NONE));
      1: push_meas(8'($urandom));
      default: begin
        case ($urandom_range(2))
          0:       b = BYTE_SYNC;
          1:       b = BYTE_ACK_TAIL;
          default: b = 8'($urandom);
        endcase
        push_ack(b, 1'($urandom), 1'($urandom));
      end
    endcase
  endtask

  // Send one twelve-byte measurement frame; optionally mix other words in.
  task automatic push_meas_frame(logic [15:0] temp, logic [7:0] hum, bit good, bit mix);
    logic [7:0] frame [MEAS_FRAME_LEN];
    logic [7:0] x;
    x = '0;
    for (int i = 0; i < MEAS_FRAME_LEN - 1; i++) begin
      frame[i] = 8'($urandom);
      if (i == TEMP_HI_POS) frame[i] = temp[15:8];
      if (i == TEMP_LO_POS) frame[i] = temp[7:0];
      if (i == HUM_POS)     frame[i] = hum;
      x ^= frame[i];
    end
    frame[MEAS_FRAME_LEN-1] = good ? (BYTE_ONES - x)
                                   : ((BYTE_ONES - x) ^ 8'($urandom_range(255, 1)));
    for (int i = 0; i < MEAS_FRAME_LEN; i++) begin
      // interleave words of the other kinds; they must not move the byte count
      if (mix && $urandom_range(99) < 10) begin
        case ($urandom_range(2))
          0:       push_random_send();
          1:       push_ack(8'($urandom), 1'($urandom), 1'($urandom));
          default: drive_word(random_fields(ACT_NONE));
        endcase
      end
      push_meas(frame[i]);
    end
  endtask

  task automatic push_ack_frame(bit head_ok, bit tail_ok, int mids);
    push_ack(head_ok ? BYTE_SYNC : 8'($urandom), 1'b1, 1'b0);
    repeat (mids) push_ack(8'($urandom), 1'b0, 1'b0);
    push_ack(tail_ok ? BYTE_ACK_TAIL : 8'($urandom), 1'b0, 1'b1);
  endtask

  // Drop valid and wait for every predicted word to come out.
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          base;
    int unsigned pick;
    bit          pressed;
    logic [15:0] temp;
    in_item_t    spare;
    pressed = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // acknowledge tail before any head: head flag is still clear
    push_ack(BYTE_ACK_TAIL, 1'b0, 1'b1);
    // good frame: AA, filler, 79
    push_ack(BYTE_SYNC, 1'b1, 1'b0);
    push_ack(8'h00, 1'b0, 1'b0);
    push_ack(BYTE_ACK_TAIL, 1'b0, 1'b1);
    // one byte that is both head and tail can never pass
    push_ack(BYTE_SYNC, 1'b1, 1'b1);
    push_ack(BYTE_ACK_TAIL, 1'b1, 1'b1);
    // bad head, then bad tail
    push_ack(8'h00, 1'b1, 1'b0);
    push_ack(BYTE_ACK_TAIL, 1'b0, 1'b1);
    push_ack(BYTE_SYNC, 1'b1, 1'b0);
    push_ack(8'h78, 1'b0, 1'b1);
    // ignored action
    drive_word(random_fields(ACT_NONE));
    // shortest and longest frames, then lengths that saturate
    push_send(8'h00, 3'd0, '0);
    push_send(8'hFF, 3'd5, '1);
    spare = random_fields(ACT_SEND);
    push_send(8'($urandom), 3'd7, spare.pay);
    spare = random_fields(ACT_SEND);
    push_send(8'($urandom), 3'd6, spare.pay);
    // most negative temperature, full humidity
    push_meas_frame(16'h8000, 8'hFF, 1'b1, 1'b0);

    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      quiet = (items_sent >= base + 120) && (items_sent < base + 200);

      // hold the receiver off while sends keep coming, then drain
      if (!pressed && items_sent >= base + 60) begin
        pressed = 1'b1;
        hold_pending = 1'b1;
        repeat (8) push_random_send();
        pause_until_drained();
      end

      pick = $urandom_range(99);
      if (pick < 35) begin
        case ($urandom_range(5))
          0:       temp = 16'h7FFF;
          1:       temp = 16'h8000;
          2:       temp = 16'h0000;
          3:       temp = 16'hFFFF;
          default: temp = 16'($urandom);
        endcase
        push_meas_frame(temp, 8'($urandom), $urandom_range(99) < 80, 1'($urandom));
      end else if (pick < 60) begin
        push_random_send();
      end else if (pick < 85) begin
        push_ack_frame($urandom_range(99) < 85, $urandom_range(99) < 85, $urandom_range(3));
      end else if (pick < 97) begin
        push_noise();
      end else begin
        pause_until_drained();
      end
    end

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Check every result word at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
